[hdl/ale_pkg.sv]
// Shared types and constants for the array list engine.
// No dependencies; imported by ale_ctrl, ale_dp, the top and the testbench.
`default_nettype none

package ale_pkg;

  localparam int Capacity = 16;
  localparam int IdxW     = $clog2(Capacity);
  localparam int FillW    = $clog2(Capacity + 1);
  localparam int ValueW   = 8;
  localparam int FuncW    = 2;
  localparam int StatusW  = 2;
  localparam int PosW     = 4;
  localparam int FillOutW = 5;

  typedef enum logic [FuncW-1:0] {
    OP_CLEAR  = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2,
    OP_FIND   = 2'd3
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_DONE    = 2'd0,
    ST_FULL    = 2'd1,
    ST_MISSING = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_INS_HEAD,
    S_SCAN,
    S_FINISH
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;
    logic ins_run;
    logic ins_head;
    logic scan_run;
    logic finish;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic ins_end;
    logic scan_end;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

[hdl/ale_ram.sv]
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`default_nettype none

module ale_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[hdl/ale_ctrl.sv]
// Sequencer for the array list engine: accepts an item and steps the datapath.
// Depends on ale_pkg.
`default_nettype none

module ale_ctrl import ale_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  input  wire op_e   func_i,
  input  wire stat_t stat_i,
  output cmd_t       cmd_o,
  output logic       in_stall_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = (state_q != S_IDLE);
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          unique case (func_i)
            OP_CLEAR:  state_d = S_FINISH;
            OP_INSERT: state_d = stat_i.full ? S_FINISH : S_INS;
            OP_DELETE: state_d = S_SCAN;
            OP_FIND:   state_d = S_SCAN;
            default:   state_d = S_SCAN;
          endcase
        end
      end
      S_INS: begin
        cmd_o.ins_run = 1'b1;
        if (stat_i.ins_end) begin
          state_d = S_INS_HEAD;
        end
      end
      S_INS_HEAD: begin
        cmd_o.ins_head = 1'b1;
        state_d        = S_FINISH;
      end
      S_SCAN: begin
        cmd_o.scan_run = 1'b1;
        if (stat_i.scan_end) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        // hold until the output register can take the result beat
        if (stat_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

[hdl/ale_dp.sv]
// Datapath of the array list engine: entry RAM, walk counters, compare and
// result register. Depends on ale_pkg and ale_ram.
`default_nettype none

module ale_dp import ale_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire cmd_t                cmd_i,
  input  wire op_e                 func_i,
  input  wire logic [ValueW-1:0]   value_i,
  input  wire logic                out_stall_i,
  output stat_t                    stat_o,
  output logic                     out_valid_o,
  output logic [StatusW-1:0]       status_o,
  output logic [PosW-1:0]          position_o,
  output logic [FillOutW-1:0]      fill_after_o
);

  // control state
  logic             out_valid_q;
  logic [FillW-1:0] fill_q, fill_d;
  logic             pend_v_q, chk_v_q, hit_q;

  // payload state
  op_e              op_q;
  logic [ValueW-1:0] value_q;
  logic [FillW-1:0] cnt_q, wr_q;
  logic [IdxW-1:0]  pend_addr_q, chk_idx_q, pos_q;
  status_e          status_q, status_d;
  logic [IdxW-1:0]  res_pos_q, res_pos_d;

  // RAM port signals
  logic              ram_we, ram_re;
  logic [IdxW-1:0]   ram_waddr, ram_raddr;
  logic [ValueW-1:0] ram_wdata, ram_rdata;

  logic match, is_find, issue, full;

  ale_ram #(
    .Width (ValueW),
    .Depth (Capacity)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign full    = (fill_q == FillW'(Capacity));
  assign match   = chk_v_q && (ram_rdata == value_q);
  assign is_find = (op_q == OP_FIND);
  // stop issuing reads once a find has hit
  assign issue   = (cnt_q < fill_q) && !(is_find && hit_q);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pend_addr_q;
    ram_wdata = ram_rdata;
    ram_re    = 1'b0;
    ram_raddr = IdxW'(cnt_q);
    if (cmd_i.ins_run) begin
      ram_we    = pend_v_q;
      ram_re    = (cnt_q != '0);
      ram_raddr = IdxW'(cnt_q - FillW'(1));
    end else if (cmd_i.ins_head) begin
      ram_we    = 1'b1;
      ram_waddr = '0;
      ram_wdata = value_q;
    end else if (cmd_i.scan_run) begin
      ram_re = issue;
      // compact: write kept entries down to the write pointer
      if ((op_q == OP_DELETE) && chk_v_q && !match) begin
        ram_we    = 1'b1;
        ram_waddr = IdxW'(wr_q);
      end
    end
  end

  always_comb begin
    fill_d    = fill_q;
    status_d  = ST_DONE;
    res_pos_d = '0;
    unique case (op_q)
      OP_CLEAR: fill_d = '0;
      OP_INSERT: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          fill_d = fill_q + FillW'(1);
        end
      end
      OP_DELETE: begin
        fill_d   = wr_q;
        status_d = hit_q ? ST_DONE : ST_MISSING;
      end
      OP_FIND: begin
        status_d  = hit_q ? ST_DONE : ST_MISSING;
        res_pos_d = hit_q ? pos_q : '0;
      end
      default: fill_d = fill_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      fill_q      <= '0;
      pend_v_q    <= 1'b0;
      chk_v_q     <= 1'b0;
      hit_q       <= 1'b0;
    end else begin
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
        fill_q      <= fill_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.start) begin
        pend_v_q <= 1'b0;
        chk_v_q  <= 1'b0;
        hit_q    <= 1'b0;
      end else begin
        if (cmd_i.ins_run) begin
          pend_v_q <= (cnt_q != '0);
        end
        if (cmd_i.scan_run) begin
          chk_v_q <= issue;
          if (match) begin
            hit_q <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      op_q    <= func_i;
      value_q <= value_i;
      cnt_q   <= (func_i == OP_INSERT) ? fill_q : '0;
      wr_q    <= '0;
    end
    if (cmd_i.ins_run && (cnt_q != '0)) begin
      pend_addr_q <= IdxW'(cnt_q);
      cnt_q       <= cnt_q - FillW'(1);
    end
    if (cmd_i.scan_run) begin
      if (issue) begin
        chk_idx_q <= IdxW'(cnt_q);
        cnt_q     <= cnt_q + FillW'(1);
      end
      if (match && !hit_q) begin
        pos_q <= chk_idx_q;
      end
      if ((op_q == OP_DELETE) && chk_v_q && !match) begin
        wr_q <= wr_q + FillW'(1);
      end
    end
    if (cmd_i.finish) begin
      status_q  <= status_d;
      res_pos_q <= res_pos_d;
    end
  end

  assign stat_o.full     = full;
  assign stat_o.ins_end  = (cnt_q == '0);
  assign stat_o.scan_end = !chk_v_q && !issue;
  assign stat_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign position_o   = PosW'(res_pos_q);
  assign fill_after_o = FillOutW'(fill_q);

endmodule

`default_nettype wire

[hdl/array_list_engine_top.sv]
// Array list engine. One item at a time: clear and an insert into a full list
// go straight to the result, insert shifts every held entry up a slot and writes
// the new value at the head, find and delete scan the entries (a find stops
// reading at its first match). The walks go over the entry RAM through its
// single read and single write port. A new item is accepted while a result
// beat waits. Reset (rst_ni low, async) empties the list.
`default_nettype none

module array_list_engine_top import ale_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [FuncW-1:0]    func_i,
  input  wire logic [ValueW-1:0]   value_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [StatusW-1:0]       status_o,
  output logic [PosW-1:0]          position_o,
  output logic [FillOutW-1:0]      fill_after_o
);

  cmd_t  cmd;
  stat_t stat;
  op_e   func;

  assign func = op_e'(func_i);

  ale_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .func_i     (func),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o)
  );

  ale_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .func_i       (func),
    .value_i      (value_i),
    .out_stall_i  (out_stall_i),
    .stat_o       (stat),
    .out_valid_o  (out_valid_o),
    .status_o     (status_o),
    .position_o   (position_o),
    .fill_after_o (fill_after_o)
  );

`ifndef NO_ASSERTIONS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input accepted while an item is in work");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == ST_DONE) || (status_o == ST_FULL) ||
                    (status_o == ST_MISSING))
    else $error("undefined status code on result beat");

  a_position_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_DONE) |-> position_o == '0)
    else $error("nonzero position on a failed operation");
`endif

endmodule

`default_nettype wire

[tb/sv/array_list_engine_top_tb.sv]
// Self-checking testbench for array_list_engine_top: clear, insert, delete and find.
// A list predictor in a small scoreboard class checks every result beat.
// Depends on ale_pkg and the array_list_engine_top RTL only.
`timescale 1ns / 1ps

module array_list_engine_top_tb;
  import ale_pkg::*;

  localparam int HoldCycles = 300;
  localparam int IdleLimit  = 3000;
  localparam int TailCycles = Capacity + 8;

  typedef struct packed {
    status_e               status;
    logic [PosW-1:0]       position;
    logic [FillOutW-1:0]   fill;
  } list_result_t;

  class list_scoreboard;
    logic [ValueW-1:0] held [Capacity];
    int unsigned       count;
    list_result_t      expected_q[$];
    int unsigned       fails;

    function new();
      count = 0;
      fails = 0;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    task report_mismatch(input string msg);
      $display("%0t ns: mismatch: %s", $time, msg);
      fails++;
    endtask

    // Apply one accepted item to the list and queue the result it must give.
    function void note_item(input op_e op, input logic [ValueW-1:0] v);
      list_result_t r;
      int unsigned  kept;
      bit           hit;
      r.status   = ST_DONE;
      r.position = '0;
      case (op)
        OP_CLEAR: begin
          count = 0;
        end
        OP_INSERT: begin
          if (count >= Capacity) begin
            r.status = ST_FULL;
          end else begin
            for (int i = count; i > 0; i--) held[i] = held[i-1];
            held[0] = v;
            count++;
          end
        end
        OP_DELETE: begin
          kept = 0;
          hit  = 1'b0;
          for (int i = 0; i < count; i++) begin
            if (held[i] == v) begin
              hit = 1'b1;
            end else begin
              held[kept] = held[i];
              kept++;
            end
          end
          count = kept;
          if (!hit) r.status = ST_MISSING;
        end
        default: begin
          r.status = ST_MISSING;
          for (int i = 0; i < count && r.status == ST_MISSING; i++) begin
            if (held[i] == v) begin
              r.status   = ST_DONE;
              r.position = PosW'(i);
            end
          end
        end
      endcase
      r.fill = FillOutW'(count);
      expected_q.push_back(r);
    endfunction

    task check_result(input logic [StatusW-1:0] st, input logic [PosW-1:0] pos,
                      input logic [FillOutW-1:0] fill);
      list_result_t r;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result status=%0d position=%0d fill=%0d",
                                  st, pos, fill));
      end else begin
        r = expected_q.pop_front();
        if (st !== r.status)
          report_mismatch($sformatf("status %0d, want %0d", st, r.status));
        if (pos !== r.position)
          report_mismatch($sformatf("position %0d, want %0d", pos, r.position));
        if (fill !== r.fill)
          report_mismatch($sformatf("fill_after %0d, want %0d", fill, r.fill));
      end
    endtask
  endclass

  logic                  clk_i        = 1'b0;
  logic                  rst_ni       = 1'b0;
  logic                  in_valid_i   = 1'b0;
  logic [FuncW-1:0]      func_i       = '0;
  logic [ValueW-1:0]     value_i      = '0;
  logic                  out_stall_i  = 1'b0;
  logic                  in_stall_o;
  logic                  out_valid_o;
  logic [StatusW-1:0]    status_o;
  logic [PosW-1:0]       position_o;
  logic [FillOutW-1:0]   fill_after_o;

  list_scoreboard        sb = new();
  bit                    smooth   = 1'b0;
  bit                    hold_req = 1'b0;
  logic [ValueW-1:0]     value_pool [8];

  array_list_engine_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .func_i       (func_i),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .position_o   (position_o),
    .fill_after_o (fill_after_o)
  );

  always #5 clk_i = ~clk_i;

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned idle_len();
    case ($urandom_range(0, 19))
      0:       return $urandom_range(20, 60);
      1, 2, 3: return $urandom_range(3, 8);
      default: return $urandom_range(0, 2);
    endcase
  endfunction

  function automatic op_e pick_op(input bit grow);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 2) return OP_CLEAR;
    if (grow) return (r < 65) ? OP_INSERT : (r < 85) ? OP_FIND : OP_DELETE;
    return (r < 30) ? OP_INSERT : (r < 60) ? OP_FIND : OP_DELETE;
  endfunction

  // Draw mostly from a small pool so finds and deletes hit held entries.
  function automatic logic [ValueW-1:0] pick_value();
    if ($urandom_range(0, 4) != 0) return value_pool[$urandom_range(0, 7)];
    return ValueW'($urandom_range(0, 255));
  endfunction

  task automatic send_item(input op_e op, input logic [ValueW-1:0] v);
    int unsigned gap;
    gap = smooth ? 0 : idle_len();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i     <= op;
    value_i    <= v;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic run_random(input int n);
    bit grow;
    grow = 1'b1;
    for (int k = 0; k < n; k++) begin
      if (k % 40 == 0) begin
        grow = ($urandom_range(0, 2) != 0);
        foreach (value_pool[j]) value_pool[j] = ValueW'($urandom_range(0, 255));
      end
      send_item(pick_op(grow), pick_value());
    end
  endtask

  // Score every accepted beat on both channels.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i)
        sb.check_result(status_o, position_o, fill_after_o);
      if (in_valid_i && !in_stall_o)
        sb.note_item(op_e'(func_i), value_i);
    end
  end

  initial begin : receiver
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        hold_req = 1'b0;
        out_stall_i <= 1'b0;
      end else if (smooth || $urandom_range(0, 2) != 0) begin
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= 1'b1;
        repeat (idle_len()) @(posedge clk_i);
      end
    end
  end

  initial begin : watchdog
    int unsigned idle;
    idle = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle = 0;
      else idle++;
      if (idle >= IdleLimit) break;
    end
    $display("** array_list_engine_top: FAILED **");
    $finish;
  end

  initial begin : stimulus
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty list: clear, find miss, delete miss.
    send_item(OP_CLEAR, 8'h00);
    send_item(OP_FIND, 8'h5A);
    send_item(OP_DELETE, 8'h5A);
    // Fill to capacity with duplicates; the extremes end up at the tail (highest positions).
    send_item(OP_INSERT, 8'hFF);
    send_item(OP_INSERT, 8'h00);
    for (int i = 0; i < Capacity - 2; i++)
      send_item(OP_INSERT, ValueW'(8'h10 + (i % 5) * 8'h11));
    // Full list: drop the insert.
    send_item(OP_INSERT, 8'h99);
    send_item(OP_FIND, 8'hFF);
    send_item(OP_FIND, 8'h00);
    send_item(OP_FIND, ValueW'(8'h10 + ((Capacity - 3) % 5) * 8'h11));
    send_item(OP_FIND, 8'h99);
    send_item(OP_DELETE, 8'h21);
    send_item(OP_DELETE, 8'h77);
    send_item(OP_CLEAR, 8'hA5);
    wait_drained();

    run_random(300);

    // Stall the output long enough to back up the input, then drain.
    smooth   = 1'b1;
    hold_req = 1'b1;
    run_random(50);
    wait_drained();

    run_random(200);
    smooth = 1'b0;
    run_random(350);

    wait_drained();
    repeat (TailCycles) @(posedge clk_i);
    if (sb.pending() != 0)
      sb.report_mismatch($sformatf("%0d results never arrived", sb.pending()));
    if (sb.fails == 0) begin
      $display("** array_list_engine_top: PASSED **");
    end else begin
      $display("** array_list_engine_top: FAILED **");
    end
    $finish;
  end

endmodule
